[rtl/core/gbci_pkg.sv]
// Shared types and constants for the gyro bias-calibrated integrator.
`default_nettype none
package gbci_pkg;

  localparam int AXES      = 3;
  localparam int FRAC_BITS = 32;
  localparam int LANES     = 3;

  localparam int RATE_W  = 16;
  localparam int TS_W    = 32;
  localparam int CAL_W   = 12;
  localparam int ANGLE_W = 64;
  localparam int DELTA_W = 49;
  localparam int BIAS_W  = 49;
  localparam int SUM_W   = 61;
  localparam int SHIFT   = 32 - FRAC_BITS;

  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd1;

  localparam logic [CAL_W-1:0] CAL_COUNT_RST = 12'd300;
  localparam logic [TS_W-1:0]  TIME_STEP_RST = 32'd536871;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
  } in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic signed [ANGLE_W-1:0] angle_z;
    logic                      calibrating;
  } out_t;

  typedef struct packed {
    logic load_prod;
    logic step;
    logic div_init;
    logic div_step;
    logic div_end;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic cal_done;
  } sts_t;

endpackage
`default_nettype wire

[rtl/core/gyro_bias_calibrated_integrator_top.sv]
// Top level of the gyro bias-calibrated integrator.
// Usage:
//   in_*  : one transaction carries a three-axis signed rate sample.
//   out_* : one transaction per sample: three Q31.32 angles and a
//           calibrating flag (angles read zero while it is set).
//   cfg_* : write enable, index and data; index 0 sets the calibration
//           count, index 1 the time step. Write only while idle.
// Timing: a sample is multiplied and registered in the cycle it is accepted,
// then folded into the sums or angles and the output register once the output
// slot is free; no new sample is taken until then, as set by the
// multiply-then-accumulate sequence of the controller.
// After the last calibration sample the bias divider runs one quotient
// bit per cycle, and in_ready stays low until the bias is loaded.
// Reset: synchronous, active low; restores register defaults and starts a
// new calibration. If the receiver stalls, the finished result holds in the
// output register; one more sample is accepted and waits behind it.
`default_nettype none
module gyro_bias_calibrated_integrator_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire gbci_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output gbci_pkg::out_t                       out_data,
  input  wire logic                            cfg_we,
  input  wire logic [gbci_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gbci_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gbci_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gbci_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbci_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[rtl/core/gbci_ctrl.sv]
// Controller: handshakes, item sequencing and bias divider stepping.
`default_nettype none
module gbci_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire gbci_pkg::sts_t sts,
  output gbci_pkg::cmd_t     cmd
);
  import gbci_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ACC      = 3'd1;
  localparam logic [2:0] S_DIV_INIT = 3'd2;
  localparam logic [2:0] S_DIV_STEP = 3'd3;
  localparam logic [2:0] S_DIV_END  = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_prod = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      S_ACC: begin
        if (slot_free) begin
          cmd.step  = 1'b1;
          state_nxt = (!sts.running && sts.cal_done) ? S_DIV_INIT : S_IDLE;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(SUM_W - 1)) state_nxt = S_DIV_END;
      end
      S_DIV_END: begin
        cmd.div_end = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.step) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/gbci_datapath.sv]
// Datapath: rate multipliers, calibration sums, bias divider and angle accumulators.
`default_nettype none
module gbci_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire gbci_pkg::in_t                       in_data,
  input  wire logic                                cfg_we,
  input  wire logic [gbci_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gbci_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire gbci_pkg::cmd_t                      cmd,
  output gbci_pkg::sts_t                           sts,
  output gbci_pkg::out_t                           out_data
);
  import gbci_pkg::*;

  logic [CAL_W-1:0] cal_count_r;
  logic [TS_W-1:0]  time_step_r;
  logic             running_r;
  logic [CAL_W-1:0] calib_seen_r;

  logic signed [DELTA_W-1:0] prod_r     [LANES];
  logic signed [SUM_W-1:0]   calib_sum_r[LANES];
  logic signed [BIAS_W-1:0]  bias_r     [LANES];
  logic signed [ANGLE_W-1:0] acc_r      [LANES];
  logic [SUM_W-1:0]          quo_r      [LANES];
  logic [CAL_W-1:0]          rem_r      [LANES];
  logic                      neg_r      [LANES];
  out_t                      out_data_r;

  logic signed [RATE_W-1:0]  rate_a   [LANES];
  logic signed [DELTA_W-1:0] mul      [LANES];
  logic signed [DELTA_W-1:0] delta    [LANES];
  logic signed [SUM_W-1:0]   sum_add  [LANES];
  logic signed [ANGLE_W:0]   acc_sum  [LANES];
  logic signed [ANGLE_W-1:0] acc_sat  [LANES];
  logic signed [ANGLE_W-1:0] out_ang  [LANES];
  logic [SUM_W-1:0]          mag      [LANES];
  logic [CAL_W:0]            shifted  [LANES];
  logic [CAL_W:0]            trial    [LANES];
  logic [SUM_W-1:0]          quo_sgn  [LANES];

  logic [CAL_W-1:0] target;
  logic [CAL_W-1:0] seen_inc;
  logic [CAL_W-1:0] seen_next;

  always_comb begin
    rate_a[0] = in_data.rate_x;
    rate_a[1] = in_data.rate_y;
    rate_a[2] = in_data.rate_z;
    target    = (cal_count_r == '0) ? CAL_W'(1) : cal_count_r;
    seen_inc  = calib_seen_r + CAL_W'(1);
    seen_next = (seen_inc == '0) ? CAL_W'(1) : seen_inc;
    for (int i = 0; i < LANES; i++) begin
      mul[i]     = DELTA_W'(rate_a[i]) * DELTA_W'($signed({1'b0, time_step_r}));
      delta[i]   = (i < AXES) ? (prod_r[i] >>> SHIFT) : '0;
      sum_add[i] = calib_sum_r[i]
                 + {{(SUM_W-DELTA_W){delta[i][DELTA_W-1]}}, delta[i]};
      acc_sum[i] = {acc_r[i][ANGLE_W-1], acc_r[i]}
                 + {{(ANGLE_W+1-DELTA_W){delta[i][DELTA_W-1]}}, delta[i]}
                 - {{(ANGLE_W+1-BIAS_W){bias_r[i][BIAS_W-1]}}, bias_r[i]};
      if (acc_sum[i][ANGLE_W] != acc_sum[i][ANGLE_W-1])
        acc_sat[i] = acc_sum[i][ANGLE_W] ? ANGLE_MIN : ANGLE_MAX;
      else
        acc_sat[i] = acc_sum[i][ANGLE_W-1:0];
      out_ang[i] = (i < AXES) ? acc_sat[i] : '0;
      mag[i]     = calib_sum_r[i][SUM_W-1] ? (~calib_sum_r[i] + SUM_W'(1))
                                           : calib_sum_r[i];
      shifted[i] = {rem_r[i], quo_r[i][SUM_W-1]};
      trial[i]   = shifted[i] - {1'b0, calib_seen_r};
      quo_sgn[i] = neg_r[i] ? (~quo_r[i] + SUM_W'(1)) : quo_r[i];
    end
  end

  assign sts.running  = running_r;
  assign sts.cal_done = (seen_next >= target);
  assign out_data     = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_count_r  <= CAL_COUNT_RST;
      time_step_r  <= TIME_STEP_RST;
      running_r    <= 1'b0;
      calib_seen_r <= '0;
      for (int i = 0; i < LANES; i++) begin
        calib_sum_r[i] <= '0;
        bias_r[i]      <= '0;
        acc_r[i]       <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CAL_COUNT) cal_count_r <= cfg_data[CAL_W-1:0];
        else if (cfg_index == CFG_TIME_STEP) time_step_r <= cfg_data[TS_W-1:0];
      end
      if (cmd.step) begin
        if (running_r) begin
          for (int i = 0; i < LANES; i++) acc_r[i] <= acc_sat[i];
        end else begin
          for (int i = 0; i < LANES; i++) calib_sum_r[i] <= sum_add[i];
          calib_seen_r <= seen_next;
        end
      end
      if (cmd.div_end) begin
        for (int i = 0; i < LANES; i++) begin
          bias_r[i]      <= quo_sgn[i][BIAS_W-1:0];
          calib_sum_r[i] <= '0;
          acc_r[i]       <= '0;
        end
        calib_seen_r <= '0;
        running_r    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_prod) begin
      for (int i = 0; i < LANES; i++) prod_r[i] <= mul[i];
    end
    if (cmd.step) begin
      if (running_r) begin
        out_data_r.angle_x     <= out_ang[0];
        out_data_r.angle_y     <= out_ang[1];
        out_data_r.angle_z     <= out_ang[2];
        out_data_r.calibrating <= 1'b0;
      end else begin
        out_data_r.angle_x     <= '0;
        out_data_r.angle_y     <= '0;
        out_data_r.angle_z     <= '0;
        out_data_r.calibrating <= 1'b1;
      end
    end
    if (cmd.div_init) begin
      for (int i = 0; i < LANES; i++) begin
        quo_r[i] <= mag[i];
        neg_r[i] <= calib_sum_r[i][SUM_W-1];
        rem_r[i] <= '0;
      end
    end
    if (cmd.div_step) begin
      for (int i = 0; i < LANES; i++) begin
        if (!trial[i][CAL_W]) begin
          rem_r[i] <= trial[i][CAL_W-1:0];
          quo_r[i] <= {quo_r[i][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[i] <= shifted[i][CAL_W-1:0];
          quo_r[i] <= {quo_r[i][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the gyro bias-calibrated integrator: directed, random and large-step runs.
module testbench;
  import gbci_pkg::*;

  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int SETTLE_CYCLES    = 80;
  localparam int RANDOM_PER_PHASE = 230;
  localparam int SAT_CHUNK        = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic signed [RATE_W-1:0] RATE_MAX = 16'sh7FFF;
  localparam logic signed [RATE_W-1:0] RATE_MIN = 16'sh8000;
  localparam logic [TS_W-1:0]          DT_MAX   = 32'hFFFF_FFFF;
  localparam logic [TS_W-1:0]          DT_MIN   = 32'd1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // integrator copy: configuration and per-axis state
  logic [CAL_W-1:0] cal_len     = CAL_COUNT_RST;
  logic [TS_W-1:0]  dt_q32      = TIME_STEP_RST;
  longint           angle_state [3] = '{0, 0, 0};
  longint           bias_state  [3] = '{0, 0, 0};
  longint           cal_total   [3] = '{0, 0, 0};
  logic [CAL_W-1:0] cal_taken   = '0;
  bit               tracking    = 1'b0;

  in_t         rate_q[$];
  out_t        predicted_angles_q[$];
  int          rates_queued  = 0;
  int          rates_taken   = 0;
  bit          rate_accepted = 1'b0;
  int          errors        = 0;
  int          quiet         = 0;
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 79;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  gyro_bias_calibrated_integrator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic out_t integrate_sample(in_t s);
    logic signed [RATE_W-1:0]  rates [3];
    longint                    rate_dt [3];
    longint                    outs [3];
    logic signed [ANGLE_W:0]   acc_ext;
    logic signed [ANGLE_W:0]   step_ext;
    logic signed [ANGLE_W:0]   wide;
    logic [CAL_W-1:0]          target;
    longint                    seen_l;
    out_t                      res;
    int                        i;
    rates[0] = s.rate_x;
    rates[1] = s.rate_y;
    rates[2] = s.rate_z;
    for (i = 0; i < 3; i++) begin
      rate_dt[i] = (i < AXES) ? longint'(rates[i]) * longint'({32'd0, dt_q32}) : 0;
      outs[i] = 0;
    end
    res = '0;
    if (!tracking) begin
      target = (cal_len == '0) ? CAL_W'(1) : cal_len;
      for (i = 0; i < 3; i++) cal_total[i] += rate_dt[i];
      cal_taken = cal_taken + 1'b1;
      if (cal_taken == '0) cal_taken = CAL_W'(1);
      if (cal_taken >= target) begin
        seen_l = cal_taken;
        for (i = 0; i < 3; i++) begin
          bias_state[i]  = cal_total[i] / seen_l;
          cal_total[i]   = 0;
          angle_state[i] = 0;
        end
        cal_taken = '0;
        tracking  = 1'b1;
      end
      res.calibrating = 1'b1;
    end else begin
      for (i = 0; i < 3; i++) begin
        if (i < AXES) begin
          acc_ext  = angle_state[i];
          step_ext = rate_dt[i] - bias_state[i];
          wide     = acc_ext + step_ext;
          if (wide[ANGLE_W] != wide[ANGLE_W-1]) begin
            angle_state[i] = wide[ANGLE_W] ? ANGLE_MIN : ANGLE_MAX;
          end else begin
            angle_state[i] = wide[ANGLE_W-1:0];
          end
          outs[i] = angle_state[i];
        end
      end
      res.angle_x     = outs[0];
      res.angle_y     = outs[1];
      res.angle_z     = outs[2];
      res.calibrating = 1'b0;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [ANGLE_W-1:0] want,
                             input logic [ANGLE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted_angles_q.push_back(integrate_sample(in_data));
        rates_taken++;
        rate_accepted = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (predicted_angles_q.size() == 0) begin
          errors++;
          $display("%0t unexpected transaction, actual %h", $time, out_data);
        end else begin
          want = predicted_angles_q.pop_front();
          check_field("angle_x", want.angle_x, out_data.angle_x);
          check_field("angle_y", want.angle_y, out_data.angle_y);
          check_field("angle_z", want.angle_z, out_data.angle_z);
          check_field("calibrating", want.calibrating, out_data.calibrating);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk) begin : driver
    logic next_valid;
    in_t  next_data;
    next_valid = in_valid;
    next_data  = in_data;
    if (rate_accepted) begin
      next_valid    = 1'b0;
      rate_accepted = 1'b0;
    end
    if (!next_valid && rst_n && rate_q.size() != 0 &&
        $urandom_range(0, 99) >= send_idle_pct) begin
      next_data  = rate_q.pop_front();
      next_valid = 1'b1;
    end
    in_valid  <= next_valid;
    in_data   <= next_data;
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic signed [RATE_W-1:0] rand_rate();
    unique case ($urandom_range(0, 15))
      0:       return RATE_MAX;
      1:       return RATE_MIN;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return RATE_W'($urandom);
    endcase
  endfunction

  function automatic logic [TS_W-1:0] rand_dt();
    unique case ($urandom_range(0, 3))
      0:       return TIME_STEP_RST;
      1:       return $urandom_range(1, 65535);
      default: return $urandom_range(1, 32'hFFFF_FFFF);
    endcase
  endfunction

  task automatic push_rates(input logic signed [RATE_W-1:0] x,
                            input logic signed [RATE_W-1:0] y,
                            input logic signed [RATE_W-1:0] z);
    in_t s;
    s.rate_x = x;
    s.rate_y = y;
    s.rate_z = z;
    rate_q.push_back(s);
    rates_queued++;
  endtask

  task automatic run_random(input int n);
    repeat (n) push_rates(rand_rate(), rand_rate(), rand_rate());
  endtask

  task automatic settle(input int extra);
    while (!(rates_taken == rates_queued && predicted_angles_q.size() == 0)) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      CFG_CAL_COUNT: cal_len = val[CAL_W-1:0];
      CFG_TIME_STEP: dt_q32  = val[TS_W-1:0];
      default: ;
    endcase
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // calibrate on reset defaults, then bias x low and y high at the largest step
    push_rates(RATE_MAX, RATE_MIN, 16'sd0);
    push_rates(RATE_MIN, RATE_MAX, -16'sd1);
    push_rates(16'sd1, -16'sd1, RATE_MIN);
    settle(SETTLE_CYCLES);
    write_reg(CFG_TIME_STEP, DT_MAX);
    write_reg(CFG_CAL_COUNT, 12);
    repeat (6) push_rates(RATE_MIN, RATE_MAX, rand_rate());
    settle(SETTLE_CYCLES);
    write_reg(CFG_TIME_STEP, DT_MIN);
    push_rates(RATE_MAX, RATE_MIN, RATE_MAX);
    settle(SETTLE_CYCLES);
    // drop the count below the samples seen: the next sample closes calibration
    write_reg(CFG_CAL_COUNT, 0);
    push_rates(RATE_MIN, RATE_MAX, RATE_MIN);
    push_rates(RATE_MAX, RATE_MIN, 16'sd0);
    push_rates(-16'sd1, 16'sd1, RATE_MAX);
    settle(SETTLE_CYCLES);

    write_reg(CFG_CAL_COUNT, 4095);
    write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_B, 32'h0000_0001);
    write_reg(CFG_TIME_STEP, DT_MAX);
    push_rates(RATE_MAX, RATE_MIN, RATE_MAX);
    push_rates(RATE_MIN, RATE_MAX, RATE_MIN);
    push_rates(16'sd0, 16'sd0, 16'sd0);
    push_rates(-16'sd1, -16'sd1, -16'sd1);
    push_rates(16'sd1, 16'sd1, 16'sd1);
    run_random(RANDOM_PER_PHASE);
    settle(SETTLE_CYCLES);

    write_reg(CFG_TIME_STEP, rand_dt());
    write_reg(CFG_CAL_COUNT, 1);
    send_idle_pct = 79;
    recv_idle_pct = 34;
    run_random(RANDOM_PER_PHASE);
    settle(SETTLE_CYCLES);

    // drive x up and y down at the largest step
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_TIME_STEP, DT_MAX);
    repeat (SAT_CHUNK) push_rates(RATE_MAX, RATE_MIN, rand_rate());
    settle(SETTLE_CYCLES);
    write_reg(CFG_TIME_STEP, rand_dt());
    run_random(RANDOM_PER_PHASE);
    settle(SETTLE_CYCLES);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
